/* hw/rtl/tcm_pkg.sv */
`timescale 1ns / 1ps

package tcm_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_MIN   = 3'd0,
    CFG_CAL_MAX   = 3'd1,
    CFG_OUT_MIN   = 3'd2,
    CFG_OUT_MAX   = 3'd3,
    CFG_CURVE_SEL = 3'd4
  } cfg_idx_e;

  localparam logic [7:0] NEUTRAL   = 8'd128;
  localparam logic [7:0] DEAD_BAND = 8'd3;
  localparam logic [7:0] DEAD_LO   = NEUTRAL - DEAD_BAND;
  localparam logic [7:0] DEAD_HI   = NEUTRAL + DEAD_BAND;

  // divisors 127^(e-1) of the power curve
  localparam longint unsigned CurveDen2 = 64'd127;
  localparam longint unsigned CurveDen3 = 64'd16129;
  localparam longint unsigned CurveDen4 = 64'd2048383;

  // output-side settings seen by the back end
  typedef struct packed {
    logic [7:0] out_min;
    logic [7:0] out_max;
    logic [1:0] curve_sel;
    logic       cal_bad;
  } tcm_out_cfg_t;

  // one row: round(d^e / 127^(e-1)) for d = 0..127
  typedef logic [127:0][6:0] curve_row_t;

  function automatic curve_row_t build_curve(int unsigned expo);
    curve_row_t      row;
    longint unsigned num;
    longint unsigned den;
    longint unsigned acc;
    longint unsigned val;
    row = '0;
    case (expo)
      2:       den = CurveDen2;
      3:       den = CurveDen3;
      4:       den = CurveDen4;
      default: den = 64'd1;
    endcase
    for (int d = 0; d < 128; d++) begin
      num = 64'd1;
      for (int unsigned i = 0; i < expo; i++) begin
        num = num * 64'(d);
      end
      // round half up by restoring steps; the quotient fits in seven bits
      acc = 2 * num + den;
      val = 64'd0;
      for (int b = 6; b >= 0; b--) begin
        if (acc >= ((2 * den) << b)) begin
          acc = acc - ((2 * den) << b);
          val = val | (64'd1 << b);
        end
      end
      row[d] = 7'(val);
    end
    return row;
  endfunction

  localparam curve_row_t CURVE_SQ = build_curve(2);
  localparam curve_row_t CURVE_CU = build_curve(3);
  localparam curve_row_t CURVE_QU = build_curve(4);

endpackage

/* hw/rtl/throttle_curve_mapper.sv */
// Pipeline: a sample beat passes the clamp, multiply, eight restoring divider cells
//   and the curve and output stage before its result beat is offered.
// Throughput: one sample per cycle; the divider is a row of one-bit cells.
// Each stage holds its beat under back-pressure; empty stages still fill.
// Reset: asynchronous, active low; empties the pipeline and loads the
//   register defaults (full calibrated range, full output range, quartic).
`timescale 1ns / 1ps

module throttle_curve_mapper #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0] s_axis_tdata,  // [ADC_BITS-1:0] adc_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] drive_value
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADC_BITS-1:0]           cfg_data_i
);
  import tcm_pkg::*;

  localparam int unsigned NumCells = 8;
  localparam logic [ADC_BITS-1:0] CalMaxRst = ADC_BITS'(4095);

  logic [ADC_BITS-1:0] cal_min_q, cal_max_q;
  logic [7:0]          out_min_q, out_max_q;
  logic [1:0]          curve_sel_q;
  logic [ADC_BITS-1:0] range;
  tcm_out_cfg_t        out_cfg;

  logic                cell_valid [NumCells+1];
  logic                cell_ready [NumCells+1];
  logic [ADC_BITS-1:0] cell_rem   [NumCells+1];
  logic [7:0]          cell_low   [NumCells+1];
  logic [7:0]          cell_quo   [NumCells+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_min_q   <= '0;
      cal_max_q   <= CalMaxRst;
      out_min_q   <= 8'd0;
      out_max_q   <= 8'd255;
      curve_sel_q <= 2'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CAL_MIN:   cal_min_q   <= cfg_data_i;
        CFG_CAL_MAX:   cal_max_q   <= cfg_data_i;
        CFG_OUT_MIN:   out_min_q   <= cfg_data_i[7:0];
        CFG_OUT_MAX:   out_max_q   <= cfg_data_i[7:0];
        CFG_CURVE_SEL: curve_sel_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign range             = cal_max_q - cal_min_q;
  assign out_cfg.out_min   = out_min_q;
  assign out_cfg.out_max   = out_max_q;
  assign out_cfg.curve_sel = curve_sel_q;
  assign out_cfg.cal_bad   = cal_max_q <= cal_min_q;

  tcm_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .sample_i  (s_axis_tdata[ADC_BITS-1:0]),
    .cal_min_i (cal_min_q),
    .cal_max_i (cal_max_q),
    .out_cfg_i (out_cfg),
    .valid_o   (cell_valid[0]),
    .ready_i   (cell_ready[0]),
    .rem_o     (cell_rem[0]),
    .low_o     (cell_low[0])
  );

  assign cell_quo[0] = 8'd0;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    tcm_div_cell #(
      .ADC_BITS (ADC_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .range_i (range),
      .valid_i (cell_valid[k]),
      .ready_o (cell_ready[k]),
      .rem_i   (cell_rem[k]),
      .low_i   (cell_low[k]),
      .quo_i   (cell_quo[k]),
      .valid_o (cell_valid[k+1]),
      .ready_i (cell_ready[k+1]),
      .rem_o   (cell_rem[k+1]),
      .low_o   (cell_low[k+1]),
      .quo_o   (cell_quo[k+1])
    );
  end

  tcm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .out_cfg_i (out_cfg),
    .valid_i   (cell_valid[NumCells]),
    .ready_o   (cell_ready[NumCells]),
    .quo_i     (cell_quo[NumCells]),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .drive_o   (m_axis_tdata)
  );

  // final divider remainder is unused; touch it so every cell output is read
  logic rem_tail_unused;
  assign rem_tail_unused = ^{cell_rem[NumCells], cell_low[NumCells]};

  a_bad_cal_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (cal_max_q <= cal_min_q)) |-> (m_axis_tdata == NEUTRAL))
    else $error("bad calibration must give neutral");

  a_dead_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata >= DEAD_LO) && (m_axis_tdata <= DEAD_HI))
      |-> (m_axis_tdata == NEUTRAL))
    else $error("value inside dead band not snapped");

  a_empty_out_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no result pending");

endmodule

/* hw/rtl/tcm_front.sv */
`timescale 1ns / 1ps

module tcm_front #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [ADC_BITS-1:0]   sample_i,
  input  logic [ADC_BITS-1:0]   cal_min_i,
  input  logic [ADC_BITS-1:0]   cal_max_i,
  input  tcm_pkg::tcm_out_cfg_t out_cfg_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [ADC_BITS-1:0]   rem_o,
  output logic [7:0]            low_o
);
  import tcm_pkg::*;

  localparam int unsigned ProdW = ADC_BITS + 8;

  logic                valid1_q, valid2_q;
  logic                ready1, ready2;
  logic [ADC_BITS-1:0] clamp;
  logic [ADC_BITS-1:0] offs_d, offs_q;
  logic [7:0]          span;
  logic [ProdW-1:0]    prod_d, prod_q;

  assign ready2  = !valid2_q || ready_i;
  assign ready1  = !valid1_q || ready2;
  assign ready_o = ready1;

  always_comb begin
    clamp = sample_i;
    if (clamp < cal_min_i) clamp = cal_min_i;
    if (clamp > cal_max_i) clamp = cal_max_i;
    offs_d = clamp - cal_min_i;
  end

  always_comb begin
    if (out_cfg_i.out_max >= out_cfg_i.out_min) begin
      span = out_cfg_i.out_max - out_cfg_i.out_min;
    end else begin
      span = out_cfg_i.out_min - out_cfg_i.out_max;
    end
    prod_d = ProdW'(offs_q) * ProdW'(span);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (ready1) valid1_q <= valid_i;
      if (ready2) valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && valid_i) offs_q <= offs_d;
    if (ready2 && valid1_q) prod_q <= prod_d;
  end

  // product stays below range * 256, so the top part is already below range
  assign valid_o = valid2_q;
  assign rem_o   = prod_q[ProdW-1:8];
  assign low_o   = prod_q[7:0];

endmodule

/* hw/rtl/tcm_div_cell.sv */
`timescale 1ns / 1ps

module tcm_div_cell #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ADC_BITS-1:0] range_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [ADC_BITS-1:0] rem_i,
  input  logic [7:0]          low_i,
  input  logic [7:0]          quo_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [ADC_BITS-1:0] rem_o,
  output logic [7:0]          low_o,
  output logic [7:0]          quo_o
);

  logic                valid_q;
  logic [ADC_BITS:0]   trial;
  logic [ADC_BITS:0]   diff;
  logic                take;
  logic [ADC_BITS-1:0] rem_d, rem_q;
  logic [7:0]          low_q, quo_q;

  assign ready_o = !valid_q || ready_i;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    trial = {rem_i, low_i[7]};
    diff  = trial - {1'b0, range_i};
    take  = trial >= {1'b0, range_i};
    rem_d = take ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      low_q <= {low_i[6:0], 1'b0};
      quo_q <= {quo_i[6:0], take};
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign low_o   = low_q;
  assign quo_o   = quo_q;

endmodule

/* hw/rtl/tcm_back.sv */
`timescale 1ns / 1ps

module tcm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcm_pkg::tcm_out_cfg_t out_cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [7:0]            quo_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [7:0]            drive_o
);
  import tcm_pkg::*;

  logic       valid_q;
  logic [7:0] lin;
  logic [6:0] delta;
  logic [6:0] lift;
  logic [7:0] curved;
  logic [7:0] drive_d, drive_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (out_cfg_i.out_max >= out_cfg_i.out_min) begin
      lin = out_cfg_i.out_min + quo_i;
    end else begin
      lin = out_cfg_i.out_min - quo_i;
    end
    delta = lin[6:0];  // lin - 128 when above neutral
    case (out_cfg_i.curve_sel)
      2'd0:    lift = delta;
      2'd1:    lift = CURVE_SQ[delta];
      2'd2:    lift = CURVE_CU[delta];
      2'd3:    lift = CURVE_QU[delta];
      default: lift = delta;
    endcase
    curved = (lin > NEUTRAL) ? {1'b1, lift} : lin;
    if (out_cfg_i.cal_bad || (curved >= DEAD_LO && curved <= DEAD_HI)) begin
      drive_d = NEUTRAL;
    end else begin
      drive_d = curved;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) drive_q <= drive_d;
  end

  assign valid_o = valid_q;
  assign drive_o = drive_q;

endmodule

/* test/tb_throttle_curve_mapper.sv */
`timescale 1ns / 1ps

module tb_throttle_curve_mapper;
  import tcm_pkg::*;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned PIPE_LAT = 11;
  localparam int unsigned DRAIN_SLACK = PIPE_LAT + 10;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned CURVE_SPAN = 127;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd5;  // first unmapped index
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;  // [11:0] adc_sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;       // [7:0] drive_value
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SAMPLE_W-1:0]  cfg_data_i = '0;

  // register mirror
  logic [SAMPLE_W-1:0] cal_lo = '0;
  logic [SAMPLE_W-1:0] cal_hi = 12'd4095;
  logic [7:0]          out_lo = 8'd0;
  logic [7:0]          out_hi = 8'd255;
  logic [1:0]          curve_preset = 2'd3;

  logic [7:0]  drive_q[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  bit          idle_en = 1'b1;
  bit          offering = 1'b0;

  throttle_curve_mapper uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] predict_drive(logic [SAMPLE_W-1:0] sample);
    int unsigned     x;
    int unsigned     span;
    int unsigned     offs;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     v;
    int unsigned     expo;
    longint unsigned d;
    longint unsigned num;
    longint unsigned den;
    if (cal_hi <= cal_lo) return NEUTRAL;
    x = sample;
    if (x < cal_lo) x = cal_lo;
    if (x > cal_hi) x = cal_hi;
    span = cal_hi - cal_lo;
    offs = x - cal_lo;
    lo = out_lo;
    hi = out_hi;
    // reversed output range counts down from out_min
    if (hi >= lo) v = (lo + offs * (hi - lo) / span) & 8'hFF;
    else v = (lo - offs * (lo - hi) / span) & 8'hFF;
    expo = curve_preset + 1;
    if (expo > 1 && v > NEUTRAL) begin
      d = v - NEUTRAL;
      num = 1;
      den = 1;
      for (int i = 0; i < expo; i++) num = num * d;
      for (int i = 1; i < expo; i++) den = den * CURVE_SPAN;
      v = NEUTRAL + int'((2 * num + den) / (2 * den));
      if (v > 255) v = 255;
    end
    if (v >= DEAD_LO && v <= DEAD_HI) v = NEUTRAL;
    return 8'(v);
  endfunction

  // mostly near the calibrated window, some anywhere
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int lo;
    int hi;
    if (cal_hi > cal_lo && $urandom_range(0, 3) != 0) begin
      lo = (cal_lo < 16) ? 0 : int'(cal_lo) - 16;
      hi = (cal_hi > 4079) ? 4095 : int'(cal_hi) + 16;
      return 12'($urandom_range(lo, hi));
    end
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      if (offering) begin
        s_axis_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= 16'(sample);
    if (!offering) begin
      s_axis_tvalid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    drive_q.push_back(predict_drive(sample));
  endtask

  task automatic wait_drain();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_CAL_MIN:   cal_lo = value;
      CFG_CAL_MAX:   cal_hi = value;
      CFG_OUT_MIN:   out_lo = value[7:0];
      CFG_OUT_MAX:   out_hi = value[7:0];
      CFG_CURVE_SEL: curve_preset = value[1:0];
      default: ;
    endcase
  endtask

  // always followed by at least one sample before the next call
  task automatic reconfigure(input logic [SAMPLE_W-1:0] cmin, cmax, omin, omax, csel,
                             input bit stray);
    wait_drain();
    cfg_valid_i <= 1'b1;
    write_reg(CFG_CAL_MIN, cmin);
    write_reg(CFG_CAL_MAX, cmax);
    if (stray) write_reg(3'($urandom_range(CFG_IDX_NONE, CFG_IDX_TOP)), 12'($urandom));
    write_reg(CFG_OUT_MIN, omin);
    write_reg(CFG_OUT_MAX, omax);
    write_reg(CFG_CURVE_SEL, csel);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    send_sample(12'd2600);
  endtask

  task automatic test_curve_presets();
    for (int c = 0; c < 4; c++) begin
      reconfigure(12'd0, 12'd4095, 12'd0, 12'd255, 12'(c), 1'b0);
      send_sample(12'd4095);
      send_sample(12'd3000);
    end
  endtask

  task automatic test_special_cases();
    // calibration with max equal to min, then max below min
    reconfigure(12'd2000, 12'd2000, 12'd0, 12'd255, 12'd3, 1'b0);
    send_sample(12'd2500);
    reconfigure(12'd3000, 12'd1000, 12'd0, 12'd255, 12'd1, 1'b0);
    send_sample(12'd2000);
    // clamp below and above the window, linear preset
    reconfigure(12'd1000, 12'd3000, 12'd0, 12'd255, 12'd0, 1'b0);
    send_sample(12'd0);
    send_sample(12'd4095);
    // reversed output range, plus a write to an unmapped index
    reconfigure(12'd0, 12'd4095, 12'd255, 12'd0, 12'd2, 1'b1);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1000);
    // upper bits of narrow registers are dropped
    reconfigure(12'd100, 12'd4000, 12'hFC8, 12'hF37, 12'hFFE, 1'b0);
    send_sample(12'd4000);
    send_sample(12'd100);
    reconfigure(12'd0, 12'd4095, 12'd200, 12'd200, 12'd3, 1'b0);
    send_sample(12'd1234);
  endtask

  task automatic test_random_traffic();
    logic [SAMPLE_W-1:0] cmin;
    logic [SAMPLE_W-1:0] cmax;
    logic [SAMPLE_W-1:0] omin;
    logic [SAMPLE_W-1:0] omax;
    logic [SAMPLE_W-1:0] csel;
    for (int phase = 0; phase < 12; phase++) begin
      idle_en = (phase % 3 != 2);
      case ($urandom_range(0, 7))
        0: begin
          cmin = 12'($urandom_range(0, 4095));
          cmax = 12'($urandom_range(0, cmin));
        end
        1: begin
          cmin = 12'd0;
          cmax = 12'd4095;
        end
        default: begin
          cmin = 12'($urandom_range(0, 4000));
          cmax = 12'($urandom_range(cmin + 1, 4095));
        end
      endcase
      if (phase == 0) begin
        cmin = 12'd0;
        cmax = 12'd4095;
      end else if (phase == 1) begin
        cmin = 12'd4094;
        cmax = 12'd4095;
      end
      omin = 12'($urandom_range(0, 4095));
      omax = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 3) == 0) begin
        omin = $urandom_range(0, 1) ? 12'd255 : 12'd0;
        omax = 12'd255 - omin;
      end
      csel = (phase < 4) ? 12'(phase) : 12'($urandom_range(0, 4095));
      reconfigure(cmin, cmax, omin, omax, csel, $urandom_range(0, 3) == 0);
      repeat (50) send_sample(draw_sample());
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure_and_pause();
    reconfigure(12'd0, 12'd4095, 12'd0, 12'd255, 12'd3, 1'b0);
    // sink stops after its next beat while the source keeps pushing
    hold_request = LONG_HOLD;
    idle_en = 1'b0;
    repeat (40) send_sample(draw_sample());
    wait_drain();
    idle_en = 1'b1;
    repeat (10) send_sample(draw_sample());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_curve_presets();
    test_special_cases();
    test_random_traffic();
    test_backpressure_and_pause();
    wait_drain();
    repeat (DRAIN_SLACK) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result sink and checker
  initial begin : drive_sink
    int unsigned stall;
    logic [7:0]  want;
    forever begin
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_en ? $urandom_range(0, 11) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      if (drive_q.size() == 0) begin
        $display("%0t: drive_value %0d with nothing expected", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = drive_q.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: drive_value expected %0d, got %0d", $time, want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* filelist.f */
hw/rtl/tcm_pkg.sv
hw/rtl/tcm_front.sv
hw/rtl/tcm_div_cell.sv
hw/rtl/tcm_back.sv
hw/rtl/throttle_curve_mapper.sv
test/tb_throttle_curve_mapper.sv
